// ===== hw/rtl/orth_pkg.sv =====
// ----------------------------------------------------------------------------
// orth_pkg - shared constants and types for the orthocenter pipeline
// Widths of the result fields, threshold width and flag bundle.
// ----------------------------------------------------------------------------
package orth_pkg;

	localparam int COORD_BITS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int OUT_BITS          = 48;
	localparam int THRESH_BITS       = 35;
	// quotient bits kept by the divider: one above the output range
	localparam int QUOT_BITS         = OUT_BITS + 1;

	// per-item flags carried alongside the divider
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic degen;
	} orth_flags_t;

endpackage

// ===== hw/rtl/orth_front.sv =====
// ----------------------------------------------------------------------------
// orth_front - altitude coefficients, determinant and scaled numerators
// Five register stages: differences, products, constants and determinant,
// numerator products, then numerator magnitudes prepared for rounding.
// ----------------------------------------------------------------------------
module orth_front #(
	parameter int COORD_BITS    = orth_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = orth_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [COORD_BITS-1:0]        ax,
	input  logic signed [COORD_BITS-1:0]        ay,
	input  logic signed [COORD_BITS-1:0]        bx,
	input  logic signed [COORD_BITS-1:0]        by,
	input  logic signed [COORD_BITS-1:0]        cx,
	input  logic signed [COORD_BITS-1:0]        cy,
	input  logic [orth_pkg::THRESH_BITS-1:0]    thr,
	output logic [3*COORD_BITS+FRACTION_BITS+6:0] num_x,
	output logic [3*COORD_BITS+FRACTION_BITS+6:0] num_y,
	output logic [2*COORD_BITS+3:0]             den,
	output orth_pkg::orth_flags_t               flags
);

	localparam int C    = COORD_BITS;
	localparam int KW   = 2*C + 3;
	localparam int DETW = 2*C + 3;
	localparam int PW   = KW + C + 1;
	localparam int SW   = PW + 1;
	localparam int NW   = 3*C + FRACTION_BITS + 7;
	localparam int DW   = 2*C + 4;
	localparam int TW   = orth_pkg::THRESH_BITS;
	localparam int CW   = (DETW > TW) ? DETW : TW;

	// stage 1: edge differences
	logic signed [C:0]   aa_s1, ab_s1, ba_s1, bb_s1;
	logic signed [C-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	// stage 2: first products
	logic signed [2*C:0]   pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [2*C+1:0] pe_s2, pf_s2;
	logic signed [C:0]     aa_s2, ab_s2, ba_s2, bb_s2;
	// stage 3: altitude constants and determinant
	logic signed [KW-1:0]   ka_s3, kb_s3;
	logic signed [DETW-1:0] det_s3;
	logic signed [C:0]      aa_s3, ab_s3, ba_s3, bb_s3;
	// stage 4: numerator products
	logic signed [PW-1:0]   px1_s4, px2_s4, py1_s4, py2_s4;
	logic [DETW-1:0]        dmag_s4;
	logic                   dneg_s4, degen_s4;
	// stage 5: scaled magnitudes
	logic [NW-1:0]          nx_s5, ny_s5;
	logic [DW-1:0]          den_s5;
	orth_pkg::orth_flags_t  fl_s5;

	logic [DETW-1:0]      dmag_c;
	logic signed [SW-1:0] nx_c, ny_c;
	logic [SW-1:0]        mx_c, my_c;

	assign dmag_c = det_s3[DETW-1] ? DETW'(-det_s3) : DETW'(det_s3);
	assign nx_c   = SW'(px1_s4) - SW'(px2_s4);
	assign ny_c   = SW'(py1_s4) - SW'(py2_s4);
	assign mx_c   = nx_c[SW-1] ? SW'(-nx_c) : SW'(nx_c);
	assign my_c   = ny_c[SW-1] ? SW'(-ny_c) : SW'(ny_c);

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1 <= $signed({cx[C-1], cx}) - $signed({bx[C-1], bx});
			ab_s1 <= $signed({cy[C-1], cy}) - $signed({by[C-1], by});
			ba_s1 <= $signed({ax[C-1], ax}) - $signed({cx[C-1], cx});
			bb_s1 <= $signed({ay[C-1], ay}) - $signed({cy[C-1], cy});
			ax_s1 <= ax;
			ay_s1 <= ay;
			bx_s1 <= bx;
			by_s1 <= by;

			pa_s2 <= aa_s1 * ax_s1;
			pb_s2 <= ab_s1 * ay_s1;
			pc_s2 <= ba_s1 * bx_s1;
			pd_s2 <= bb_s1 * by_s1;
			pe_s2 <= aa_s1 * bb_s1;
			pf_s2 <= ab_s1 * ba_s1;
			aa_s2 <= aa_s1;
			ab_s2 <= ab_s1;
			ba_s2 <= ba_s1;
			bb_s2 <= bb_s1;

			ka_s3  <= -(KW'(pa_s2) + KW'(pb_s2));
			kb_s3  <= -(KW'(pc_s2) + KW'(pd_s2));
			det_s3 <= DETW'(pe_s2) - DETW'(pf_s2);
			aa_s3  <= aa_s2;
			ab_s3  <= ab_s2;
			ba_s3  <= ba_s2;
			bb_s3  <= bb_s2;

			// x = (ab*kb - ka*bb)/det, y = (ka*ba - aa*kb)/det
			px1_s4   <= ab_s3 * kb_s3;
			px2_s4   <= ka_s3 * bb_s3;
			py1_s4   <= ka_s3 * ba_s3;
			py2_s4   <= aa_s3 * kb_s3;
			dmag_s4  <= dmag_c;
			dneg_s4  <= det_s3[DETW-1];
			degen_s4 <= CW'(dmag_c) <= CW'(thr);

			// 2*|n|*2^F + |det|, later divided by 2*|det|: round half away
			nx_s5       <= (NW'(mx_c) << (FRACTION_BITS + 1)) + NW'(dmag_s4);
			ny_s5       <= (NW'(my_c) << (FRACTION_BITS + 1)) + NW'(dmag_s4);
			den_s5      <= {dmag_s4, 1'b0};
			fl_s5.neg_x <= nx_c[SW-1] ^ dneg_s4;
			fl_s5.neg_y <= ny_c[SW-1] ^ dneg_s4;
			fl_s5.degen <= degen_s4;
		end
	end

	assign num_x = nx_s5;
	assign num_y = ny_s5;
	assign den   = den_s5;
	assign flags = fl_s5;

endmodule

// ===== hw/rtl/orth_div.sv =====
// ----------------------------------------------------------------------------
// orth_div - pipelined restoring divider, one quotient bit per stage
// A head stage flags quotients too large for the kept bits, then one
// compare-subtract stage per quotient bit.
// ----------------------------------------------------------------------------
module orth_div #(
	parameter int NW = 71,
	parameter int DW = 36
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [NW-1:0]                 num,
	input  logic [DW-1:0]                 den,
	output logic [orth_pkg::QUOT_BITS-1:0] quo,
	output logic                          ovf
);

	localparam int QB   = orth_pkg::QUOT_BITS;
	localparam int NPW  = (NW > QB) ? NW : QB + 1;
	localparam int HW   = NPW - QB;
	localparam int CMPW = (HW > DW) ? HW : DW;

	logic [NPW-1:0] num_pad;
	logic [HW-1:0]  hi_c;

	logic [DW-1:0] rem_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [QB-1:0] low_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic          ovf_s [0:QB];

	assign num_pad = NPW'(num);
	assign hi_c    = num_pad[NPW-1:QB];

	// head stage: high part must stay below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CMPW'(hi_c) >= CMPW'(den);
			rem_s[0] <= DW'(hi_c);
			low_s[0] <= num_pad[QB-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [DW:0] t_c;
		logic        ge_c;

		assign t_c  = {rem_s[i], low_s[i][QB-1]};
		assign ge_c = t_c >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge_c ? DW'(t_c - {1'b0, den_s[i]}) : DW'(t_c);
				low_s[i+1] <= low_s[i] << 1;
				quo_s[i+1] <= {quo_s[i][QB-2:0], ge_c};
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

// ===== hw/rtl/triangle_orthocenter.sv =====
// ----------------------------------------------------------------------------
// triangle_orthocenter - orthocenter of a triangle by altitude intersection
// Streams one triangle per beat and returns one orthocenter per beat.
// ----------------------------------------------------------------------------
// Input beat (s_*): six signed vertex coordinates in s_tdata.
// Output beat (m_*): center_x and center_y, signed with FRACTION_BITS
// fraction bits, in m_tdata; degenerate and overflow flags in m_tuser.
// Config (cfg_*): one write sets degenerate_threshold; cfg_ready is always
// high. Write it only while the pipeline is empty.
// Depth: 5 front stages, 50 divider stages and 1 output stage from input
// beat to output beat; one beat per cycle sustained while not stalled.
// The divider retires one quotient bit per stage and sets the depth.
// Throughput: a new triangle can enter every cycle unless the output stalls.
// Stall: when m_tready is low with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits and the threshold to zero.
// Degenerate triangles give zero coordinates; out-of-range coordinates
// saturate and set overflow.
// ----------------------------------------------------------------------------
module triangle_orthocenter #(
	parameter int COORD_BITS    = orth_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = orth_pkg::FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// a_x, a_y, b_x, b_y, c_x, c_y (COORD_BITS each), zero pad
	input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// center_x [47:0], center_y [95:48]
	output logic [2*orth_pkg::OUT_BITS-1:0]  m_tdata,
	// degenerate [0], overflow [1]
	output logic [1:0]                       m_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [orth_pkg::THRESH_BITS-1:0] cfg_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready
);

	localparam int C   = COORD_BITS;
	localparam int OB  = orth_pkg::OUT_BITS;
	localparam int QB  = orth_pkg::QUOT_BITS;
	localparam int NW  = 3*C + FRACTION_BITS + 7;
	localparam int DW  = 2*C + 4;
	localparam int LAT = 5 + QB + 2;

	logic                            en;
	logic [LAT-1:0]                  vld_q;
	logic [orth_pkg::THRESH_BITS-1:0] thr_q;

	logic [NW-1:0]         num_x, num_y;
	logic [DW-1:0]         den;
	orth_pkg::orth_flags_t fl_front;
	orth_pkg::orth_flags_t fl_s [0:QB];
	logic [QB-1:0]         qx, qy;
	logic                  ox, oy;

	logic [QB-1:0] lim_x_c, lim_y_c, vx_c, vy_c;
	logic          sat_x_c, sat_y_c;

	logic [OB-1:0] cx_q, cy_q;
	logic          degen_q, ovf_q;

	// whole pipeline advances unless a result is held
	assign en        = !vld_q[LAT-1] || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	orth_front #(
		.COORD_BITS   (COORD_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk  (clk),
		.en   (en),
		.ax   ($signed(s_tdata[0*C +: C])),
		.ay   ($signed(s_tdata[1*C +: C])),
		.bx   ($signed(s_tdata[2*C +: C])),
		.by   ($signed(s_tdata[3*C +: C])),
		.cx   ($signed(s_tdata[4*C +: C])),
		.cy   ($signed(s_tdata[5*C +: C])),
		.thr  (thr_q),
		.num_x(num_x),
		.num_y(num_y),
		.den  (den),
		.flags(fl_front)
	);

	orth_div #(.NW(NW), .DW(DW)) u_div_x (
		.clk(clk), .en(en), .num(num_x), .den(den), .quo(qx), .ovf(ox)
	);

	orth_div #(.NW(NW), .DW(DW)) u_div_y (
		.clk(clk), .en(en), .num(num_y), .den(den), .quo(qy), .ovf(oy)
	);

	// flags ride alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			fl_s[0] <= fl_front;
			for (int i = 0; i < QB; i++) begin
				fl_s[i+1] <= fl_s[i];
			end
		end
	end

	// saturation limits: 2^47 for negative results, 2^47-1 otherwise
	assign lim_x_c = (QB'(1) << (OB - 1)) - QB'(!fl_s[QB].neg_x);
	assign lim_y_c = (QB'(1) << (OB - 1)) - QB'(!fl_s[QB].neg_y);
	assign sat_x_c = ox || (qx > lim_x_c);
	assign sat_y_c = oy || (qy > lim_y_c);
	assign vx_c    = sat_x_c ? lim_x_c : qx;
	assign vy_c    = sat_y_c ? lim_y_c : qy;

	// output stage
	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= fl_s[QB].degen;
			if (fl_s[QB].degen) begin
				cx_q  <= '0;
				cy_q  <= '0;
				ovf_q <= 1'b0;
			end else begin
				cx_q  <= fl_s[QB].neg_x ? OB'(-vx_c) : OB'(vx_c);
				cy_q  <= fl_s[QB].neg_y ? OB'(-vy_c) : OB'(vy_c);
				ovf_q <= sat_x_c || sat_y_c;
			end
		end
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {cy_q, cx_q};
	assign m_tuser  = {ovf_q, degen_q};

	// degenerate result carries zero coordinates and no overflow
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
		else $error("degenerate result with nonzero payload");

	// input side ready follows the output stall exactly
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output stall");

	// an overflowed result has at least one coordinate at a bound
	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |->
			(m_tdata[OB-2:0] == '0) || (m_tdata[OB-2:0] == '1) ||
			(m_tdata[2*OB-2:OB] == '0) || (m_tdata[2*OB-2:OB] == '1))
		else $error("overflow flagged without saturated coordinate");

endmodule
